[hw/rtl/cbd_pkg.sv]
`default_nettype none
package cbd_pkg;

   localparam int unsigned IDX_W      = 14;
   localparam int unsigned CODE_W     = 7;
   localparam int unsigned SIZE_W     = 7;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 14;
   localparam int unsigned RAD_W      = 8;
   localparam int unsigned ELEM_COUNT = 109;
   localparam logic [IDX_W-1:0] IDX_MAX = '1;

   localparam logic [CSR_IDX_W-1:0] CSR_ATOMS_A = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT_A = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ATOMS_B = 2'd2;

   localparam logic [RAD_W-1:0] RADIUS_ROM [ELEM_COUNT] = '{
      8'd30,  8'd116, 8'd123, 8'd89,  8'd88,  8'd77,  8'd70,  8'd66,  8'd58,  8'd55,
      8'd140, 8'd136, 8'd125, 8'd117, 8'd110, 8'd111, 8'd99,  8'd158, 8'd203, 8'd174,
      8'd144, 8'd132, 8'd120, 8'd113, 8'd117, 8'd116, 8'd116, 8'd115, 8'd117, 8'd125,
      8'd125, 8'd122, 8'd121, 8'd117, 8'd114, 8'd189, 8'd225, 8'd192, 8'd162, 8'd145,
      8'd134, 8'd129, 8'd123, 8'd124, 8'd125, 8'd128, 8'd134, 8'd141, 8'd150, 8'd140,
      8'd141, 8'd137, 8'd133, 8'd209, 8'd235, 8'd198, 8'd169, 8'd165, 8'd165, 8'd164,
      8'd164, 8'd166, 8'd185, 8'd161, 8'd159, 8'd159, 8'd158, 8'd157, 8'd156, 8'd170,
      8'd156, 8'd144, 8'd134, 8'd130, 8'd128, 8'd126, 8'd126, 8'd129, 8'd134, 8'd144,
      8'd155, 8'd154, 8'd152, 8'd153, 8'd152, 8'd153, 8'd245, 8'd202, 8'd170, 8'd163,
      8'd146, 8'd140, 8'd136, 8'd125, 8'd157, 8'd158, 8'd154, 8'd153, 8'd184, 8'd161,
      8'd150, 8'd149, 8'd138, 8'd136, 8'd126, 8'd120, 8'd116, 8'd114, 8'd106
   };

   typedef struct packed {
      logic busy;
      logic issue;
   } back_status_type;

   function automatic logic [RAD_W-1:0] radius_of(input logic [CODE_W-1:0] code);
      radius_of = (code < CODE_W'(ELEM_COUNT)) ? RADIUS_ROM[code] : RADIUS_ROM[0];
   endfunction

endpackage
`default_nettype wire

[hw/rtl/covalent_bond_detector.sv]
// Back end: an atom in slot s > 0 of its molecule is compared in turn with the s earlier atoms
//   of that molecule, using the single compare pipeline over the atom store; it takes the next
//   atom only once that pipeline has drained. An atom in slot 0 needs no compares.
// A two-beat queue lets the front take atoms while the back end compares.
// Reset (synchronous): counters and handshakes clear; config returns to 1, 0, 1.
`default_nettype none
module covalent_bond_detector import cbd_pkg::*; #(
   parameter int unsigned MAX_MOL_ATOMS = 64,
   parameter int unsigned MAX_ATOMS     = 16383,
   parameter int unsigned COORD_BITS    = 20
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [CSR_IDX_W-1:0]         csr_index,
   input  wire logic [CSR_DATA_W-1:0]        csr_data,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [CODE_W-1:0]            req_element_code,
   input  wire logic signed [COORD_BITS-1:0] req_x_pos,
   input  wire logic signed [COORD_BITS-1:0] req_y_pos,
   input  wire logic signed [COORD_BITS-1:0] req_z_pos,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [IDX_W-1:0]                  rsp_earlier_atom,
   output logic [IDX_W-1:0]                  rsp_new_atom,
   output logic                              rsp_last_of_run
);

   localparam int unsigned SW = $clog2(MAX_MOL_ATOMS);
   localparam int unsigned EW = CODE_W + 3 * COORD_BITS + SW + 2 * IDX_W;

   logic            q_push, q_full, q_pop, q_empty;
   logic [EW-1:0]   q_in, q_out;
   back_status_type st;

   assign csr_ready = 1'b1;

   cbd_front #(
      .MAX_MOL_ATOMS (MAX_MOL_ATOMS),
      .MAX_ATOMS     (MAX_ATOMS),
      .COORD_BITS    (COORD_BITS),
      .SW            (SW),
      .EW            (EW)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_element_code (req_element_code),
      .req_x_pos        (req_x_pos),
      .req_y_pos        (req_y_pos),
      .req_z_pos        (req_z_pos),
      .push             (q_push),
      .push_data        (q_in),
      .full             (q_full)
   );

   cbd_queue #(.WIDTH(EW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out),
      .empty     (q_empty)
   );

   cbd_back #(
      .MAX_MOL_ATOMS (MAX_MOL_ATOMS),
      .COORD_BITS    (COORD_BITS),
      .SW            (SW),
      .EW            (EW)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .pop              (q_pop),
      .pop_data         (q_out),
      .empty            (q_empty),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_earlier_atom (rsp_earlier_atom),
      .rsp_new_atom     (rsp_new_atom),
      .rsp_last_of_run  (rsp_last_of_run),
      .status           (st)
   );

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat valid right after reset");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("back end took an entry from an empty queue");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !st.issue)
      else $error("compare issued while result beat is stalled");

endmodule
`default_nettype wire

[hw/rtl/cbd_ram.sv]
`default_nettype none
module cbd_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

[hw/rtl/cbd_queue.sv]
`default_nettype none
module cbd_queue #(
   parameter int unsigned WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output logic                  empty
);

   logic [WIDTH-1:0] ent_ff [2];
   logic             wr_ff, wr_in;
   logic             rd_ff, rd_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full     = cnt_ff == 2'd2;
   assign empty    = cnt_ff == 2'd0;
   assign pop_data = ent_ff[rd_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_in  = do_push ? !wr_ff : wr_ff;
      rd_in  = do_pop ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         ent_ff[wr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

[hw/rtl/cbd_front.sv]
`default_nettype none
module cbd_front import cbd_pkg::*; #(
   parameter int unsigned MAX_MOL_ATOMS = 64,
   parameter int unsigned MAX_ATOMS     = 16383,
   parameter int unsigned COORD_BITS    = 20,
   parameter int unsigned SW            = $clog2(MAX_MOL_ATOMS),
   parameter int unsigned EW            = CODE_W + 3 * COORD_BITS + SW + 2 * IDX_W
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_valid,
   input  wire logic [CSR_IDX_W-1:0]         csr_index,
   input  wire logic [CSR_DATA_W-1:0]        csr_data,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [CODE_W-1:0]            req_element_code,
   input  wire logic signed [COORD_BITS-1:0] req_x_pos,
   input  wire logic signed [COORD_BITS-1:0] req_y_pos,
   input  wire logic signed [COORD_BITS-1:0] req_z_pos,
   output logic                              push,
   output logic      [EW-1:0]                push_data,
   input  wire logic                         full
);

   localparam int unsigned CNT_W = $clog2(MAX_ATOMS + 1);
   localparam int unsigned CW    = (SW + 1 > SIZE_W) ? SW + 1 : SIZE_W;

   typedef struct packed {
      logic [CODE_W-1:0]     code;
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [COORD_BITS-1:0] z;
      logic [SW-1:0]         slot;
      logic [IDX_W-1:0]      idx;
      logic [IDX_W-1:0]      first;
   } entry_type;

   logic [SIZE_W-1:0] apm_a_ff, apm_b_ff;
   logic [IDX_W-1:0]  cnt_a_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [SW-1:0]     slot_ff, slot_in;
   logic [IDX_W-1:0]  first_ff, first_in;
   logic [IDX_W-1:0]  done_ff, done_in;

   logic              acc, live, in_a, close;
   logic [SIZE_W-1:0] sel;
   logic [CW-1:0]     sel_w, size;
   logic [SW:0]       slot_nx;
   logic [IDX_W-1:0]  idx14;
   entry_type         ent;

   assign req_stall = full;
   assign acc       = req_valid && !full;
   assign live      = count_ff < CNT_W'(MAX_ATOMS);
   assign in_a      = done_ff < cnt_a_ff;
   assign push      = acc && live;
   assign push_data = ent;

   always_comb begin
      sel      = in_a ? apm_a_ff : apm_b_ff;
      sel_w    = CW'(sel);
      if (sel == '0) begin
         size = CW'(1);
      end else if (sel_w > CW'(MAX_MOL_ATOMS)) begin
         size = CW'(MAX_MOL_ATOMS);
      end else begin
         size = sel_w;
      end
      slot_nx  = {1'b0, slot_ff} + (SW + 1)'(1);
      close    = CW'(slot_nx) >= size;
      count_in = count_ff + CNT_W'(1);
      idx14    = IDX_W'(count_in);
      slot_in  = close ? '0 : slot_nx[SW-1:0];
      first_in = close ? idx14 + IDX_W'(1) : first_ff;
      done_in  = (close && in_a && done_ff != IDX_MAX) ? done_ff + IDX_W'(1) : done_ff;
      ent.code  = req_element_code;
      ent.x     = req_x_pos;
      ent.y     = req_y_pos;
      ent.z     = req_z_pos;
      ent.slot  = slot_ff;
      ent.idx   = idx14;
      ent.first = first_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         apm_a_ff <= SIZE_W'(1);
         cnt_a_ff <= '0;
         apm_b_ff <= SIZE_W'(1);
         count_ff <= '0;
         slot_ff  <= '0;
         first_ff <= IDX_W'(1);
         done_ff  <= '0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_ATOMS_A: apm_a_ff <= csr_data[SIZE_W-1:0];
               CSR_COUNT_A: cnt_a_ff <= csr_data;
               CSR_ATOMS_B: apm_b_ff <= csr_data[SIZE_W-1:0];
               default: ;
            endcase
         end
         if (push) begin
            count_ff <= count_in;
            slot_ff  <= slot_in;
            first_ff <= first_in;
            done_ff  <= done_in;
         end
      end
   end

endmodule
`default_nettype wire

[hw/rtl/cbd_back.sv]
`default_nettype none
module cbd_back import cbd_pkg::*; #(
   parameter int unsigned MAX_MOL_ATOMS = 64,
   parameter int unsigned COORD_BITS    = 20,
   parameter int unsigned SW            = $clog2(MAX_MOL_ATOMS),
   parameter int unsigned EW            = CODE_W + 3 * COORD_BITS + SW + 2 * IDX_W
) (
   input  wire logic             clock,
   input  wire logic             reset,
   output logic                  pop,
   input  wire logic [EW-1:0]    pop_data,
   input  wire logic             empty,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [IDX_W-1:0]      rsp_earlier_atom,
   output logic [IDX_W-1:0]      rsp_new_atom,
   output logic                  rsp_last_of_run,
   output back_status_type       status
);

   localparam int unsigned AW  = (COORD_BITS + 1 > 18) ? COORD_BITS + 1 : 18;
   localparam int unsigned D2W = 36;
   localparam int unsigned LW  = D2W + 5;
   localparam logic [AW-1:0] FAR_LIMIT = AW'(65536);

   typedef struct packed {
      logic [CODE_W-1:0]     code;
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [COORD_BITS-1:0] z;
      logic [SW-1:0]         slot;
      logic [IDX_W-1:0]      idx;
      logic [IDX_W-1:0]      first;
   } entry_type;

   entry_type                cur_ff, in_ent;
   logic                     busy_ff;
   logic [SW-1:0]            k_ff, k1_ff;
   logic                     v1_ff, last1_ff;
   logic                     v2_ff, last2_ff, far2_ff;
   logic [IDX_W-1:0]         earl2_ff;
   logic [33:0]              sq_ff [3];
   logic [17:0]              ss_ff;
   logic                     pend_v_ff;
   logic [IDX_W-1:0]         pend_e_ff, pend_n_ff;
   logic                     fl_ff;
   logic                     out_v_ff;
   logic [IDX_W-1:0]         out_e_ff, out_n_ff;
   logic                     out_l_ff;

   logic                     adv, issue, tok_last;
   logic [3*COORD_BITS-1:0]  coord_q;
   logic [CODE_W-1:0]        elem_q;
   logic signed [COORD_BITS-1:0] pa [3];
   logic signed [COORD_BITS-1:0] pb [3];
   logic signed [COORD_BITS:0]   dif [3];
   logic [AW-1:0]            mag [3];
   logic [16:0]              m17 [3];
   logic [33:0]              sq [3];
   logic                     far;
   logic [8:0]               rsum;
   logic [D2W-1:0]           d2;
   logic [LW-1:0]            lhs, rhs;
   logic                     bond;

   assign in_ent           = pop_data;
   assign adv              = !out_v_ff || !rsp_stall;
   assign pop              = !busy_ff && !v1_ff && !v2_ff && !fl_ff && !empty;
   assign issue            = busy_ff && adv;
   assign tok_last         = k_ff == cur_ff.slot - SW'(1);
   assign rsp_valid        = out_v_ff;
   assign rsp_earlier_atom = out_e_ff;
   assign rsp_new_atom     = out_n_ff;
   assign rsp_last_of_run  = out_l_ff;
   assign status.busy      = busy_ff;
   assign status.issue     = issue;

   cbd_ram #(.WIDTH(3 * COORD_BITS), .DEPTH(MAX_MOL_ATOMS)) u_coord_ram (
      .clock   (clock),
      .wr_en   (pop),
      .wr_addr (in_ent.slot),
      .wr_data ({in_ent.x, in_ent.y, in_ent.z}),
      .rd_en   (adv),
      .rd_addr (k_ff),
      .rd_data (coord_q)
   );

   cbd_ram #(.WIDTH(CODE_W), .DEPTH(MAX_MOL_ATOMS)) u_elem_ram (
      .clock   (clock),
      .wr_en   (pop),
      .wr_addr (in_ent.slot),
      .wr_data (in_ent.code),
      .rd_en   (adv),
      .rd_addr (k_ff),
      .rd_data (elem_q)
   );

   always_comb begin
      pa[0] = coord_q[3*COORD_BITS-1:2*COORD_BITS];
      pa[1] = coord_q[2*COORD_BITS-1:COORD_BITS];
      pa[2] = coord_q[COORD_BITS-1:0];
      pb[0] = cur_ff.x;
      pb[1] = cur_ff.y;
      pb[2] = cur_ff.z;
      far   = 1'b0;
      for (int i = 0; i < 3; i++) begin
         dif[i] = (COORD_BITS + 1)'(pa[i]) - (COORD_BITS + 1)'(pb[i]);
         mag[i] = dif[i][COORD_BITS] ? AW'(-dif[i]) : AW'(dif[i]);
         if (mag[i] > FAR_LIMIT) begin
            far = 1'b1;
         end
         m17[i] = mag[i][16:0];
         sq[i]  = 34'(m17[i]) * 34'(m17[i]);
      end
      rsum = 9'(radius_of(elem_q)) + 9'(radius_of(cur_ff.code));
      d2   = D2W'(sq_ff[0]) + D2W'(sq_ff[1]) + D2W'(sq_ff[2]);
      lhs  = (LW'(d2) << 4) + (LW'(d2) << 3) + LW'(d2);
      rhs  = LW'(ss_ff) << 8;
      bond = v2_ff && !far2_ff && (lhs <= rhs);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         fl_ff     <= 1'b0;
         pend_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         if (pop) begin
            busy_ff <= in_ent.slot != '0;
         end else if (issue && tok_last) begin
            busy_ff <= 1'b0;
         end
         if (adv) begin
            v1_ff    <= issue;
            v2_ff    <= v1_ff;
            fl_ff    <= v2_ff && last2_ff;
            out_v_ff <= 1'b0;
            if (bond) begin
               pend_v_ff <= 1'b1;
               out_v_ff  <= pend_v_ff;
            end else if (fl_ff) begin
               pend_v_ff <= 1'b0;
               out_v_ff  <= pend_v_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= in_ent;
         k_ff   <= '0;
      end else if (issue) begin
         k_ff <= k_ff + SW'(1);
      end
      if (adv) begin
         last1_ff <= tok_last;
         k1_ff    <= k_ff;
         last2_ff <= last1_ff;
         far2_ff  <= far;
         earl2_ff <= cur_ff.first + IDX_W'(k1_ff);
         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= sq[i];
         end
         ss_ff <= 18'(rsum) * 18'(rsum);
         if (bond) begin
            pend_e_ff <= earl2_ff;
            pend_n_ff <= cur_ff.idx;
            out_e_ff  <= pend_e_ff;
            out_n_ff  <= pend_n_ff;
            out_l_ff  <= 1'b0;
         end else if (fl_ff) begin
            out_e_ff <= pend_e_ff;
            out_n_ff <= pend_n_ff;
            out_l_ff <= 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

[sim/covalent_bond_detector_tb.sv]
`timescale 1ns / 100ps
module covalent_bond_detector_tb import cbd_pkg::*; ();

   typedef struct {
      logic [CODE_W-1:0] code;
      logic signed [19:0] x;
      logic signed [19:0] y;
      logic signed [19:0] z;
   } atom_type;

   typedef struct {
      logic [IDX_W-1:0] earlier;
      logic [IDX_W-1:0] newer;
      logic             last;
   } bond_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;
   logic                  req_valid;
   logic                  req_stall;
   logic [CODE_W-1:0]     req_element_code;
   logic signed [19:0]    req_x_pos;
   logic signed [19:0]    req_y_pos;
   logic signed [19:0]    req_z_pos;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [IDX_W-1:0]      rsp_earlier_atom;
   logic [IDX_W-1:0]      rsp_new_atom;
   logic                  rsp_last_of_run;

   atom_type atom_q[$];
   bond_type bond_q[$];
   int    errors = 0;
   int    send_idle_pct = 0;
   int    recv_stall_pct = 0;
   logic  hold_off = 1'b0;
   event  hold_trig;

   // mirrored block state
   int      size_a, cnt_a, size_b;
   longint  pos_mem[64][3];
   logic [CODE_W-1:0] code_mem[64];
   int      atom_cnt, slot_pos, first_idx, mol_a_done;

   // cluster generator state
   longint  base_x, base_y, base_z;

   covalent_bond_detector uut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_element_code(req_element_code),
      .req_x_pos(req_x_pos), .req_y_pos(req_y_pos), .req_z_pos(req_z_pos),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_earlier_atom(rsp_earlier_atom), .rsp_new_atom(rsp_new_atom),
      .rsp_last_of_run(rsp_last_of_run)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
   endtask

   function automatic int radius_lookup(input logic [CODE_W-1:0] code);
      return (code < ELEM_COUNT) ? int'(RADIUS_ROM[code]) : int'(RADIUS_ROM[0]);
   endfunction

   task automatic predict_bonds(input logic [CODE_W-1:0] code, input longint px,
                                input longint py, input longint pz);
      bit     in_a;
      bit     far;
      int     sz, slot, k, j, n, idx;
      longint c[3];
      longint d, d2, s;
      bond_type b;
      if (atom_cnt >= 16383) return;
      c[0] = px; c[1] = py; c[2] = pz;
      in_a = mol_a_done < cnt_a;
      sz = in_a ? size_a : size_b;
      if (sz == 0) sz = 1;
      if (sz > 64) sz = 64;
      slot = (slot_pos >= 64) ? 63 : slot_pos;
      atom_cnt++;
      idx = atom_cnt;
      n = 0;
      for (k = 0; k < slot; k++) begin
         d2 = 0;
         far = 0;
         for (j = 0; j < 3; j++) begin
            d = pos_mem[k][j] - c[j];
            if (d < 0) d = -d;
            if (d > 65536) far = 1;
            d2 += d * d;
         end
         s = radius_lookup(code_mem[k]) + radius_lookup(code);
         if (!far && 25 * d2 <= 256 * s * s) begin
            b.earlier = IDX_W'(first_idx + k);
            b.newer = IDX_W'(idx);
            b.last = 1'b0;
            bond_q.insert(bond_q.size(), b);
            n++;
         end
      end
      if (n > 0) bond_q[bond_q.size()-1].last = 1'b1;
      for (j = 0; j < 3; j++) pos_mem[slot][j] = c[j];
      code_mem[slot] = code;
      slot++;
      if (slot >= sz) begin
         slot = 0;
         if (in_a && mol_a_done < 16383) mol_a_done++;
         first_idx = idx + 1;
      end
      slot_pos = slot;
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input int value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= CSR_DATA_W'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_ATOMS_A: size_a = value & 8'h7f;
         CSR_COUNT_A: cnt_a = value & 16'h3fff;
         CSR_ATOMS_B: size_b = value & 8'h7f;
         default: ;
      endcase
   endtask

   task automatic set_sizes(input int a, input int cnt, input int b);
      write_csr(CSR_ATOMS_A, a);
      write_csr(CSR_COUNT_A, cnt);
      write_csr(CSR_ATOMS_B, b);
   endtask

   task automatic push_atom(input int code, input longint x, input longint y,
                            input longint z);
      atom_type a;
      a.code = CODE_W'(code);
      a.x = 20'(x);
      a.y = 20'(y);
      a.z = 20'(z);
      atom_q.insert(atom_q.size(), a);
   endtask

   function automatic longint rand_coord();
      return longint'($signed(20'($urandom)));
   endfunction

   task automatic push_random(input int count);
      int i, code;
      for (i = 0; i < count; i++) begin
         if ($urandom_range(99) < 15) begin
            base_x = rand_coord();
            base_y = rand_coord();
            base_z = rand_coord();
         end
         code = ($urandom_range(99) < 85) ? $urandom_range(0, 108)
                                          : $urandom_range(109, 127);
         if ($urandom_range(99) < 80)
            push_atom(code, base_x + $signed($urandom_range(0, 800)) - 400,
                      base_y + $signed($urandom_range(0, 800)) - 400,
                      base_z + $signed($urandom_range(0, 800)) - 400);
         else
            push_atom(code, rand_coord(), rand_coord(), rand_coord());
      end
   endtask

   task automatic wait_drained();
      while (atom_q.size() != 0 || req_valid) @(posedge clock);
      while (bond_q.size() != 0) @(posedge clock);
      repeat (220) @(posedge clock);
   endtask

   // driver
   always @(posedge clock) begin
      atom_type a;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            predict_bonds(req_element_code, longint'(req_x_pos),
                          longint'(req_y_pos), longint'(req_z_pos));
         if (!req_valid || !req_stall) begin
            if (atom_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               a = atom_q.pop_front();
               req_valid <= 1'b1;
               req_element_code <= a.code;
               req_x_pos <= a.x;
               req_y_pos <= a.y;
               req_z_pos <= a.z;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      bond_type b;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (bond_q.size() == 0) begin
               report_mismatch($sformatf("unexpected bond %0d-%0d",
                                         rsp_earlier_atom, rsp_new_atom));
            end else begin
               b = bond_q.pop_front();
               if (rsp_earlier_atom !== b.earlier)
                  report_mismatch($sformatf("earlier_atom %0d, want %0d",
                                            rsp_earlier_atom, b.earlier));
               if (rsp_new_atom !== b.newer)
                  report_mismatch($sformatf("new_atom %0d, want %0d",
                                            rsp_new_atom, b.newer));
               if (rsp_last_of_run !== b.last)
                  report_mismatch($sformatf("last_of_run %0b, want %0b",
                                            rsp_last_of_run, b.last));
            end
         end
         rsp_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
      end
   end

   initial begin
      forever begin
         @(hold_trig);
         hold_off <= 1'b1;
         repeat (3000) @(posedge clock);
         hold_off <= 1'b0;
      end
   end

   initial begin
      #20_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      int p;
      int cfg[6][3] = '{'{0, 3, 127}, '{64, 16383, 1}, '{2, 5, 3},
                        '{7, 1, 64}, '{1, 0, 5}, '{3, 2, 8}};
      int idle_mode[6][2] = '{'{0, 0}, '{60, 0}, '{0, 60}, '{31, 31},
                              '{0, 0}, '{60, 60}};
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      req_valid = 1'b0;
      req_element_code = '0;
      req_x_pos = '0;
      req_y_pos = '0;
      req_z_pos = '0;
      rsp_stall = 1'b0;
      size_a = 1; cnt_a = 0; size_b = 1;
      atom_cnt = 0; slot_pos = 0; first_idx = 1; mol_a_done = 0;
      base_x = 0; base_y = 0; base_z = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      push_atom(0, 0, 0, 0);
      push_atom(108, 524287, -524288, 524287);
      push_atom(127, -524288, 524287, -524288);
      wait_drained();

      set_sizes(4, 2, 64);
      push_atom(0, 0, 0, 0);
      push_atom(0, 192, 0, 0);
      push_atom(0, 0, 193, 0);
      push_atom(127, 0, 0, -192);
      push_atom(108, 524287, 524287, 524287);
      push_atom(54, -524288, -524288, -524288);
      push_atom(86, 524287 - 65537, 524287, 524287);
      push_atom(54, 524287, 524287, 524187);
      push_random(10);
      wait_drained();

      for (p = 0; p < 6; p++) begin
         send_idle_pct = idle_mode[p][0];
         recv_stall_pct = idle_mode[p][1];
         set_sizes(cfg[p][0], cfg[p][1], cfg[p][2]);
         if (p == 4) -> hold_trig;
         push_random(40);
         wait_drained();
      end

      send_idle_pct = 0;
      set_sizes(64, 0, 3);
      recv_stall_pct = 31;
      push_random(25);
      wait_drained();

      if (errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
